// ===== rtl/proximity_point_set_top_defines.svh =====
// ----------------------------------------------------------------------------
// Proximity point set assertion macros
// Assertion wrappers for the sequencer; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_POINT_SET_TOP_DEFINES_SVH
`define PROXIMITY_POINT_SET_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PPS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pps: assertion failed");
`define PPS_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("pps: forbidden condition");
`else
`define PPS_ASSERT(name, clk, rst_n, prop)
`define PPS_NEVER(name, clk, rst_n, expr)
`endif

`endif

// ===== rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// Proximity point set package
// Widths, codes and shared types of the point table.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int NEAR_LIMIT     = 25;
    localparam int NEAR_SPAN      = 5;

    localparam int IN_W       = 14;
    localparam int COORD_W    = 15;
    localparam int ENTRY_W    = 2 * COORD_W;
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_LOADED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDIT_MODE  = 1'd1;

    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        ACT_IGNORED   = 3'd0,
        ACT_ADDED     = 3'd1,
        ACT_DUPLICATE = 3'd2,
        ACT_REMOVED   = 3'd3,
        ACT_NONE_NEAR = 3'd4,
        ACT_FULL      = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_MOVE,
        S_DONE
    } t_state;

    typedef struct packed {
        t_action             action;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  point_count;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/pps_point_mem.sv =====
// ----------------------------------------------------------------------------
// Point memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_point_mem #(
    parameter int DEPTH = pps_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [pps_pkg::ENTRY_W-1:0]              i_wr_data,
    input  wire logic                                     i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [pps_pkg::ENTRY_W-1:0]              o_rd_data
);
    import pps_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pps_near.sv =====
// ----------------------------------------------------------------------------
// Proximity test
// Flags a stored point within squared distance 25 of the click point.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_near (
    input  wire logic [pps_pkg::COORD_W-1:0] i_px,
    input  wire logic [pps_pkg::COORD_W-1:0] i_py,
    input  wire logic [pps_pkg::ENTRY_W-1:0] i_entry,
    output logic                             o_near
);
    import pps_pkg::*;

    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic signed [3:0]       dx_s;
    logic signed [3:0]       dy_s;
    logic        [7:0]       sq_x;
    logic        [7:0]       sq_y;
    logic        [7:0]       sq_sum;
    logic                    in_box;

    always_comb begin
        dx     = signed'({1'b0, i_px}) - signed'({1'b0, i_entry[ENTRY_W-1:COORD_W]});
        dy     = signed'({1'b0, i_py}) - signed'({1'b0, i_entry[COORD_W-1:0]});
        in_box = (dx >= -(COORD_W+1)'(NEAR_SPAN)) && (dx <= (COORD_W+1)'(NEAR_SPAN)) &&
                 (dy >= -(COORD_W+1)'(NEAR_SPAN)) && (dy <= (COORD_W+1)'(NEAR_SPAN));
        dx_s   = dx[3:0];
        dy_s   = dy[3:0];
        sq_x   = 8'(dx_s * dx_s);
        sq_y   = 8'(dy_s * dy_s);
        sq_sum = 8'(sq_x + sq_y);
        o_near = in_box && (sq_sum <= 8'(NEAR_LIMIT));
    end

endmodule

`default_nettype wire

// ===== rtl/pps_ctrl.sv =====
// ----------------------------------------------------------------------------
// Point table sequencer
// Scans the memory, then appends, or moves the last entry into a freed slot.
// ----------------------------------------------------------------------------
`default_nettype none

`include "proximity_point_set_top_defines.svh"

module pps_ctrl #(
    parameter int MAX_POINTS = pps_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_map_loaded,
    input  wire logic [1:0]                                    i_edit_mode,
    input  wire logic                                          i_in_valid,
    output logic                                               o_in_stall,
    input  wire logic                                          i_pressed,
    input  wire logic                                          i_widget_busy,
    input  wire logic [pps_pkg::IN_W-1:0]                      i_pointer_x,
    input  wire logic [pps_pkg::IN_W-1:0]                      i_pointer_y,
    input  wire logic [pps_pkg::IN_W-1:0]                      i_scroll_x,
    input  wire logic [pps_pkg::IN_W-1:0]                      i_scroll_y,
    output logic [pps_pkg::COORD_W-1:0]                        o_px,
    output logic [pps_pkg::COORD_W-1:0]                        o_py,
    input  wire logic                                          i_near,
    output logic                                               o_wr_en,
    output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] o_wr_addr,
    output logic [pps_pkg::ENTRY_W-1:0]                        o_wr_data,
    output logic                                               o_rd_en,
    output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] o_rd_addr,
    input  wire logic [pps_pkg::ENTRY_W-1:0]                   i_rd_data,
    output logic                                               o_res_valid,
    input  wire logic                                          i_res_ready,
    output pps_pkg::t_result                                   o_res
);
    import pps_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    t_state             r_state,   n_state;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic [CNT_W-1:0]   r_issue,   n_issue;
    logic               r_chk_v,   n_chk_v;
    logic [IDX_W-1:0]   r_chk_idx, n_chk_idx;
    logic [IDX_W-1:0]   r_slot,    n_slot;
    logic [COORD_W-1:0] r_px,      n_px;
    logic [COORD_W-1:0] r_py,      n_py;
    t_action            r_action,  n_action;
    logic [CNT_W-1:0]   last;
    logic               mode_add;
    logic               mode_rem;

    assign mode_add = (i_edit_mode == MODE_ADD);
    assign mode_rem = (i_edit_mode == MODE_REMOVE);
    assign last     = CNT_W'(r_count - 1'b1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue     = r_issue;
        n_chk_v     = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_slot      = r_slot;
        n_px        = r_px;
        n_py        = r_py;
        n_action    = r_action;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_issue[IDX_W-1:0];
        o_wr_en     = 1'b0;
        o_wr_addr   = r_count[IDX_W-1:0];
        o_wr_data   = {r_px, r_py};
        o_res_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_px    = COORD_W'({1'b0, i_pointer_x} + {1'b0, i_scroll_x});
                    n_py    = COORD_W'({1'b0, i_pointer_y} + {1'b0, i_scroll_y});
                    n_issue = '0;
                    n_slot  = '0;
                    if (!i_pressed || i_widget_busy || !i_map_loaded ||
                        !(mode_add || mode_rem)) begin
                        n_action = ACT_IGNORED;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_chk_v && i_near) begin
                    if (mode_add) begin
                        n_action = ACT_DUPLICATE;
                        n_state  = S_DONE;
                    end else begin
                        n_slot  = r_chk_idx;
                        n_state = S_LAST;
                    end
                end else if (!r_chk_v && (r_issue == r_count)) begin
                    n_state = S_DONE;
                    if (!mode_add) begin
                        n_action = ACT_NONE_NEAR;
                    end else if (r_count >= CNT_W'(MAX_POINTS)) begin
                        n_action = ACT_FULL;
                    end else begin
                        o_wr_en  = 1'b1;
                        n_slot   = r_count[IDX_W-1:0];
                        n_count  = CNT_W'(r_count + 1'b1);
                        n_action = ACT_ADDED;
                    end
                end else if (r_issue != r_count) begin
                    o_rd_en   = 1'b1;
                    n_issue   = CNT_W'(r_issue + 1'b1);
                    n_chk_v   = 1'b1;
                    n_chk_idx = r_issue[IDX_W-1:0];
                end
            end
            S_LAST: begin
                o_rd_en   = 1'b1;
                o_rd_addr = last[IDX_W-1:0];
                n_state   = S_MOVE;
            end
            S_MOVE: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_slot;
                o_wr_data = i_rd_data;
                n_count   = last;
                n_action  = ACT_REMOVED;
                n_state   = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_chk_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_chk_v <= n_chk_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue   <= n_issue;
        r_chk_idx <= n_chk_idx;
        r_slot    <= n_slot;
        r_px      <= n_px;
        r_py      <= n_py;
        r_action  <= n_action;
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_px              = r_px;
    assign o_py              = r_py;
    assign o_res.action      = r_action;
    assign o_res.slot        = SLOT_W'(r_slot);
    assign o_res.point_count = COUNT_W'(r_count);

    `PPS_NEVER(a_count_max, i_clk, i_rst_n, r_count > CNT_W'(MAX_POINTS))
    `PPS_ASSERT(a_wr_state, i_clk, i_rst_n, o_wr_en |-> (r_state == S_SCAN || r_state == S_MOVE))
    `PPS_ASSERT(a_rd_range, i_clk, i_rst_n, o_rd_en |-> (CNT_W'(o_rd_addr) < r_count))
    `PPS_ASSERT(a_remove_dec, i_clk, i_rst_n, (r_state == S_MOVE) |=> (r_count == CNT_W'($past(r_count) - 1'b1)))

endmodule

`default_nettype wire

// ===== rtl/proximity_point_set_top.sv =====
// ----------------------------------------------------------------------------
// Proximity point set
// Click-edited table of 2-D points kept in one on-chip memory.
//
// Input channel (i_in_valid / o_in_stall) takes one click per item: button
// state, widget busy flag, pointer and scroll per axis. Output channel
// (o_out_valid / i_out_stall) returns one item per click: action, slot and
// the stored point count after the click. Configuration (map_loaded at index
// 0, edit_mode at index 1) is written through i_cfg_valid / o_cfg_ready.
// One click is handled at a time. An ignored click goes from idle straight to
// the done state, where its result waits to enter the output register. An edit
// scans the stored points one memory read a cycle, then adds, reports, or for
// a removal reads the last entry and moves it into the freed slot. The next
// click is taken once the result is registered and the sequencer is idle again.
// The single read port sets the scan rate.
// Reset empties the table and clears both configuration registers; no
// clearing pass runs. A stalled result holds in the output register; the
// next click is taken meanwhile and waits with its own result until the
// register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module proximity_point_set_top #(
    parameter int MAX_POINTS = pps_pkg::MAX_POINTS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_pressed,
    input  wire logic                              i_widget_busy,
    input  wire logic [pps_pkg::IN_W-1:0]          i_pointer_x,
    input  wire logic [pps_pkg::IN_W-1:0]          i_pointer_y,
    input  wire logic [pps_pkg::IN_W-1:0]          i_scroll_x,
    input  wire logic [pps_pkg::IN_W-1:0]          i_scroll_y,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [2:0]                             o_action,
    output logic [pps_pkg::SLOT_W-1:0]             o_slot,
    output logic [pps_pkg::COUNT_W-1:0]            o_point_count
);
    import pps_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic               r_map_loaded;
    logic [1:0]         r_edit_mode;
    logic               r_out_valid;
    t_result            r_out;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               near;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               res_valid;
    logic               res_ready;
    t_result            res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_loaded <= 1'b0;
            r_edit_mode  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAP_LOADED: r_map_loaded <= i_cfg_data[0];
                CFG_EDIT_MODE:  r_edit_mode  <= i_cfg_data;
                default:        r_edit_mode  <= r_edit_mode;
            endcase
        end
    end

    pps_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_map_loaded  (r_map_loaded),
        .i_edit_mode   (r_edit_mode),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pressed     (i_pressed),
        .i_widget_busy (i_widget_busy),
        .i_pointer_x   (i_pointer_x),
        .i_pointer_y   (i_pointer_y),
        .i_scroll_x    (i_scroll_x),
        .i_scroll_y    (i_scroll_y),
        .o_px          (px),
        .o_py          (py),
        .i_near        (near),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    pps_point_mem #(
        .DEPTH (MAX_POINTS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    pps_near u_near (
        .i_px    (px),
        .i_py    (py),
        .i_entry (rd_data),
        .o_near  (near)
    );

    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_action      = r_out.action;
    assign o_slot        = r_out.slot;
    assign o_point_count = r_out.point_count;

endmodule

`default_nettype wire

// ===== bench/pps_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Proximity point set result checker
// Follows register writes and accepted clicks, keeps its own copy of the point
// table, and compares every accepted result item field by field.
// ----------------------------------------------------------------------------
module pps_result_checker
    import pps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire logic                  i_pressed,
    input  wire logic                  i_widget_busy,
    input  wire logic [IN_W-1:0]       i_pointer_x,
    input  wire logic [IN_W-1:0]       i_pointer_y,
    input  wire logic [IN_W-1:0]       i_scroll_x,
    input  wire logic [IN_W-1:0]       i_scroll_y,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [2:0]            i_action,
    input  wire logic [SLOT_W-1:0]     i_slot,
    input  wire logic [COUNT_W-1:0]    i_point_count,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_full_seen,
    output int                         o_removed_seen
);

    localparam int REPORT_CAP = 100;

    logic [COORD_W-1:0] table_x [MAX_POINTS_DEF];
    logic [COORD_W-1:0] table_y [MAX_POINTS_DEF];
    int                 table_len = 0;
    logic               map_on    = 1'b0;
    logic [1:0]         edit_sel  = 2'd0;
    t_result            results_due [$];

    int fails_n   = 0;
    int pending_n = 0;
    int checked_n = 0;
    int full_n    = 0;
    int removed_n = 0;

    assign o_fail_count   = fails_n;
    assign o_pending      = pending_n;
    assign o_checked      = checked_n;
    assign o_full_seen    = full_n;
    assign o_removed_seen = removed_n;

    function automatic t_result apply_click(input logic pr, input logic bz,
            input logic [IN_W-1:0] px, input logic [IN_W-1:0] py,
            input logic [IN_W-1:0] sx, input logic [IN_W-1:0] sy);
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        longint             dx;
        longint             dy;
        int                 hit;
        int                 last;
        t_result            res;
        cx = {1'b0, px} + {1'b0, sx};
        cy = {1'b0, py} + {1'b0, sy};
        hit = -1;
        res.action = ACT_IGNORED;
        res.slot = '0;
        if (pr && !bz && map_on && (edit_sel == MODE_ADD || edit_sel == MODE_REMOVE)) begin
            for (int i = 0; i < table_len; i++) begin
                dx = longint'(cx) - longint'(table_x[i]);
                dy = longint'(cy) - longint'(table_y[i]);
                if (hit < 0 && dx * dx + dy * dy <= NEAR_LIMIT) begin
                    hit = i;
                end
            end
            if (edit_sel == MODE_ADD) begin
                if (hit >= 0) begin
                    res.action = ACT_DUPLICATE;
                end else if (table_len >= MAX_POINTS_DEF) begin
                    res.action = ACT_FULL;
                end else begin
                    table_x[table_len] = cx;
                    table_y[table_len] = cy;
                    res.action = ACT_ADDED;
                    res.slot = table_len[SLOT_W-1:0];
                    table_len++;
                end
            end else if (hit < 0) begin
                res.action = ACT_NONE_NEAR;
            end else begin
                // move the last entry into the freed slot
                last = table_len - 1;
                table_x[hit] = table_x[last];
                table_y[hit] = table_y[last];
                table_len = last;
                res.action = ACT_REMOVED;
                res.slot = hit[SLOT_W-1:0];
            end
        end
        res.point_count = table_len[COUNT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            table_len = 0;
            map_on = 1'b0;
            edit_sel = 2'd0;
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    if (fails_n < REPORT_CAP) begin
                        $display("%0t: unexpected result item: expected none, got action %0d slot %0d count %0d",
                                 $time, i_action, i_slot, i_point_count);
                    end
                    fails_n++;
                end else begin
                    want = results_due.pop_front();
                    checked_n++;
                    if (want.action == ACT_FULL) begin
                        full_n++;
                    end
                    if (want.action == ACT_REMOVED) begin
                        removed_n++;
                    end
                    if (i_action !== want.action) begin
                        if (fails_n < REPORT_CAP) begin
                            $display("%0t: action mismatch: expected %0d, got %0d",
                                     $time, want.action, i_action);
                        end
                        fails_n++;
                    end
                    if (i_slot !== want.slot) begin
                        if (fails_n < REPORT_CAP) begin
                            $display("%0t: slot mismatch: expected %0d, got %0d",
                                     $time, want.slot, i_slot);
                        end
                        fails_n++;
                    end
                    if (i_point_count !== want.point_count) begin
                        if (fails_n < REPORT_CAP) begin
                            $display("%0t: point count mismatch: expected %0d, got %0d",
                                     $time, want.point_count, i_point_count);
                        end
                        fails_n++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAP_LOADED: begin
                        map_on = i_cfg_data[0];
                    end
                    CFG_EDIT_MODE: begin
                        edit_sel = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                results_due.push_back(apply_click(i_pressed, i_widget_busy, i_pointer_x,
                                                  i_pointer_y, i_scroll_x, i_scroll_y));
            end
        end
        pending_n = results_due.size();
    end

endmodule

// ===== bench/proximity_point_set_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Proximity point set testbench
// Drives directed and random clicks across map and edit mode settings, with
// bursty input and a varying output stall, while the checker tracks the table.
// ----------------------------------------------------------------------------
module proximity_point_set_top_tb
    import pps_pkg::*;
;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         SUM_MAX     = 32766;
    localparam int         FIELD_MAX   = 16383;
    localparam int         CLICK_GOAL  = 1400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_pressed;
    logic                  i_widget_busy;
    logic [IN_W-1:0]       i_pointer_x;
    logic [IN_W-1:0]       i_pointer_y;
    logic [IN_W-1:0]       i_scroll_x;
    logic [IN_W-1:0]       i_scroll_y;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [2:0]            o_action;
    logic [SLOT_W-1:0]     o_slot;
    logic [COUNT_W-1:0]    o_point_count;

    int fail_count;
    int pending;
    int checked;
    int full_seen;
    int removed_seen;

    int clicks_sent  = 0;
    int phases_run   = 0;
    int burst_left   = 0;
    int unsigned spot_x [$];
    int unsigned spot_y [$];

    proximity_point_set_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pressed     (i_pressed),
        .i_widget_busy (i_widget_busy),
        .i_pointer_x   (i_pointer_x),
        .i_pointer_y   (i_pointer_y),
        .i_scroll_x    (i_scroll_x),
        .i_scroll_y    (i_scroll_y),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_action      (o_action),
        .o_slot        (o_slot),
        .o_point_count (o_point_count)
    );

    pps_result_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_pressed      (i_pressed),
        .i_widget_busy  (i_widget_busy),
        .i_pointer_x    (i_pointer_x),
        .i_pointer_y    (i_pointer_y),
        .i_scroll_x     (i_scroll_x),
        .i_scroll_y     (i_scroll_y),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_action       (o_action),
        .i_slot         (o_slot),
        .i_point_count  (o_point_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_full_seen    (full_seen),
        .o_removed_seen (removed_seen)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #20_000_000;
        $display("** proximity_point_set_top: FAILED **");
        $finish;
    end

    // output stall: free, light, heavy and long-hold stretches
    initial begin
        int style;
        int span;
        int run;
        logic hold;
        i_out_stall = 1'b0;
        forever begin
            style = $urandom_range(0, 3);
            span = $urandom_range(40, 300);
            hold = 1'b0;
            while (span > 0) begin
                if (style == 3) begin
                    hold = !hold;
                    run = hold ? $urandom_range(1, 30) : $urandom_range(1, 4);
                end else begin
                    run = 1;
                    if (style == 0) begin
                        hold = 1'b0;
                    end else if (style == 1) begin
                        hold = ($urandom_range(0, 9) < 3);
                    end else begin
                        hold = ($urandom_range(0, 9) < 8);
                    end
                end
                repeat (run) begin
                    @(negedge i_clk);
                    i_out_stall = hold;
                    span--;
                end
            end
        end
    end

    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_raw(input logic pr, input logic bz,
                            input logic [IN_W-1:0] px, input logic [IN_W-1:0] py,
                            input logic [IN_W-1:0] sx, input logic [IN_W-1:0] sy);
        i_pressed = pr;
        i_widget_busy = bz;
        i_pointer_x = px;
        i_pointer_y = py;
        i_scroll_x = sx;
        i_scroll_y = sy;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        clicks_sent++;
        pace();
    endtask

    function automatic logic [IN_W-1:0] pick_pointer(input int unsigned total);
        int unsigned lo;
        int unsigned hi;
        lo = (total > FIELD_MAX) ? total - FIELD_MAX : 0;
        hi = (total < FIELD_MAX) ? total : FIELD_MAX;
        return IN_W'($urandom_range(hi, lo));
    endfunction

    task automatic click_at(input logic pr, input logic bz,
                            input int unsigned tx, input int unsigned ty);
        logic [IN_W-1:0] px;
        logic [IN_W-1:0] py;
        px = pick_pointer(tx);
        py = pick_pointer(ty);
        send_raw(pr, bz, px, py, IN_W'(tx - px), IN_W'(ty - py));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data = value;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic int unsigned spot_coord(input int unsigned base, input int reach);
        int t;
        t = int'(base) + $urandom_range(0, 2 * reach) - reach;
        if (t < 0) begin
            t = 0;
        end
        if (t > SUM_MAX) begin
            t = SUM_MAX;
        end
        return t;
    endfunction

    function automatic int unsigned fresh_coord();
        case ($urandom_range(0, 9))
            0: return $urandom_range(15, 0);
            1: return SUM_MAX - $urandom_range(15, 0);
            default: return $urandom_range(SUM_MAX, 0);
        endcase
    endfunction

    task automatic random_click(input logic [1:0] mode);
        int r;
        int k;
        int unsigned tx;
        int unsigned ty;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            send_raw(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     IN_W'($urandom_range(FIELD_MAX, 0)), IN_W'($urandom_range(FIELD_MAX, 0)),
                     IN_W'($urandom_range(FIELD_MAX, 0)), IN_W'($urandom_range(FIELD_MAX, 0)));
        end else begin
            if (spot_x.size() > 0 && r < ((mode == MODE_REMOVE) ? 85 : 40)) begin
                k = $urandom_range(0, spot_x.size() - 1);
                tx = spot_coord(spot_x[k], (mode == MODE_REMOVE) ? 4 : 6);
                ty = spot_coord(spot_y[k], (mode == MODE_REMOVE) ? 4 : 6);
            end else begin
                tx = fresh_coord();
                ty = fresh_coord();
            end
            click_at(1'b1, 1'b0, tx, ty);
            spot_x.push_back(tx);
            spot_y.push_back(ty);
            if (spot_x.size() > 96) begin
                void'(spot_x.pop_front());
                void'(spot_y.pop_front());
            end
        end
    endtask

    initial begin
        int pick;
        int count_n;
        logic map_sel;
        logic [1:0] mode_sel;
        logic drained_once;
        drained_once = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MAP_LOADED;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_pressed = 1'b0;
        i_widget_busy = 1'b0;
        i_pointer_x = '0;
        i_pointer_y = '0;
        i_scroll_x = '0;
        i_scroll_y = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: gating, distance boundary, field extremes, removals to empty
        click_at(1'b1, 1'b0, 100, 200);
        write_reg(CFG_MAP_LOADED, 2'd1);
        click_at(1'b1, 1'b0, 100, 200);
        write_reg(CFG_EDIT_MODE, MODE_UNUSED);
        click_at(1'b1, 1'b0, 100, 200);
        write_reg(CFG_EDIT_MODE, MODE_ADD);
        send_raw(1'b1, 1'b0, '0, '0, '0, '0);
        send_raw(1'b1, 1'b0, '1, '1, '1, '1);
        click_at(1'b1, 1'b0, 3, 4);
        click_at(1'b1, 1'b0, 5, 1);
        send_raw(1'b0, 1'b0, 14'd9, 14'd9, 14'd0, 14'd0);
        send_raw(1'b1, 1'b1, 14'd9, 14'd9, 14'd0, 14'd0);
        click_at(1'b1, 1'b0, SUM_MAX - 4, SUM_MAX - 3);
        click_at(1'b1, 1'b0, 1000, 1000);
        write_reg(CFG_EDIT_MODE, MODE_REMOVE);
        click_at(1'b1, 1'b0, 0, 5);
        click_at(1'b1, 1'b0, 20000, 100);
        click_at(1'b1, 1'b0, 1000, 1000);
        click_at(1'b1, 1'b0, SUM_MAX, SUM_MAX);
        click_at(1'b1, 1'b0, 5, 1);
        click_at(1'b1, 1'b0, 5, 1);
        write_reg(CFG_MAP_LOADED, 2'd0);
        click_at(1'b1, 1'b0, 5, 1);

        while (clicks_sent < CLICK_GOAL) begin
            pick = (phases_run == 0) ? 2 : $urandom_range(0, 9);
            if (pick == 0) begin
                map_sel = 1'b0;
                mode_sel = 2'($urandom_range(0, 3));
                count_n = $urandom_range(10, 30);
            end else if (pick == 1) begin
                map_sel = 1'b1;
                mode_sel = $urandom_range(0, 1) ? MODE_OFF : MODE_UNUSED;
                count_n = $urandom_range(10, 30);
            end else begin
                map_sel = 1'b1;
                mode_sel = (pick < 6) ? MODE_ADD : MODE_REMOVE;
                count_n = (phases_run == 0) ? 130 : $urandom_range(40, 160);
            end
            write_reg(CFG_MAP_LOADED, {1'b0, map_sel});
            write_reg(CFG_EDIT_MODE, mode_sel);
            phases_run++;
            repeat (count_n) begin
                random_click(mode_sel);
                if (!drained_once && clicks_sent >= 600) begin
                    i_in_valid = 1'b0;
                    while (pending != 0) @(negedge i_clk);
                    drained_once = 1'b1;
                end
            end
        end

        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        $display("Sent %0d clicks over %0d random settings; %0d result items checked.",
                 clicks_sent, phases_run, checked);
        $display("Removals: %0d, full-table rejections: %0d.", removed_seen, full_seen);
        if (fail_count == 0) begin
            $display("** proximity_point_set_top: PASSED **");
        end else begin
            $display("** proximity_point_set_top: FAILED **");
        end
        $finish;
    end

endmodule
